@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the sha-256 stream hasher
// round constants, initial hash values, controller to datapath command and
// status structs
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockWords = 16;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      load_byte;
    byte_sel_e byte_sel;
    logic      cnt_inc;
    logic      init_work;
    logic      round_en;
    logic [5:0] round_idx;
    logic      add_hash;
    logic      new_msg;
    logic [2:0] out_idx;
  } sha_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_ge56;
  } sha_status_t;

  localparam logic [7:0] PadMark = 8'h80;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

@@ rtl/sha_dp.sv @@
// ----------------------------------------------------------------------------
// sha_dp: sha-256 datapath
// block shift line, byte and length counters, round logic, chaining words
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha_pkg::sha_cmd_t     cmd_i,
  input  logic [7:0]            data_byte_i,
  output sha_pkg::sha_status_t  status_o,
  output sha_pkg::word_t        digest_word_o
);
  import sha_pkg::*;

  word_t       msg_q [BlockWords];
  word_t       msg_d [BlockWords];
  word_t       wk_q  [NumWords];
  word_t       wk_d  [NumWords];
  word_t       h_q   [NumWords];
  word_t       h_d   [NumWords];
  logic [63:0] cnt_q, cnt_d;
  logic [5:0]  pos_q, pos_d;

  logic [63:0] len_bits;
  logic [5:0]  len_base;
  logic [7:0]  in_byte;
  word_t       w_new, s0, s1, t1, t2, ep1, ep0, ch, maj, a, e;

  assign len_bits = {cnt_q[60:0], 3'b000};
  assign len_base = {~pos_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_DATA: in_byte = data_byte_i;
      BYTE_MARK: in_byte = PadMark;
      BYTE_LEN:  in_byte = len_bits[len_base +: 8];
      default:   in_byte = 8'h00;
    endcase
  end

  // message schedule expansion and round function
  assign s0  = {msg_q[1][6:0], msg_q[1][31:7]} ^ {msg_q[1][17:0], msg_q[1][31:18]}
             ^ (msg_q[1] >> 3);
  assign s1  = {msg_q[14][16:0], msg_q[14][31:17]} ^ {msg_q[14][18:0], msg_q[14][31:19]}
             ^ (msg_q[14] >> 10);
  assign w_new = s1 + msg_q[9] + s0 + msg_q[0];

  assign a   = wk_q[0];
  assign e   = wk_q[4];
  assign ep1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ep0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch  = (e & wk_q[5]) ^ (~e & wk_q[6]);
  assign maj = (a & wk_q[1]) ^ (a & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
  assign t1  = wk_q[7] + ep1 + ch + round_const(cmd_i.round_idx) + msg_q[0];
  assign t2  = ep0 + maj;

  always_comb begin
    msg_d = msg_q;
    wk_d  = wk_q;
    h_d   = h_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.load_byte) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        msg_d[i] = {msg_q[i][23:0], msg_q[i+1][31:24]};
      end
      msg_d[BlockWords-1] = {msg_q[BlockWords-1][23:0], in_byte};
      pos_d = pos_q + 6'd1;
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 64'd1;
    end
    if (cmd_i.init_work) begin
      wk_d = h_q;
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        msg_d[i] = msg_q[i+1];
      end
      msg_d[BlockWords-1] = w_new;
      wk_d[7] = wk_q[6];
      wk_d[6] = wk_q[5];
      wk_d[5] = wk_q[4];
      wk_d[4] = wk_q[3] + t1;
      wk_d[3] = wk_q[2];
      wk_d[2] = wk_q[1];
      wk_d[1] = wk_q[0];
      wk_d[0] = t1 + t2;
    end
    if (cmd_i.add_hash) begin
      for (int i = 0; i < NumWords; i++) begin
        h_d[i] = h_q[i] + wk_q[i];
      end
    end
    if (cmd_i.new_msg) begin
      for (int i = 0; i < NumWords; i++) begin
        h_d[i] = init_hash(3'(i));
      end
      cnt_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        h_q[i] <= init_hash(3'(i));
      end
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      h_q   <= h_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    wk_q  <= wk_d;
  end

  assign status_o.pos_last = (pos_q == 6'd63);
  assign status_o.pos_ge56 = (pos_q[5:3] == 3'b111);
  assign digest_word_o     = h_q[cmd_i.out_idx];

endmodule

@@ rtl/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_ctrl: sha-256 controller
// sequences byte intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  byte_valid_i,
  input  logic                  end_of_message_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  sha_pkg::sha_status_t  status_i,
  output sha_pkg::sha_cmd_t     cmd_o
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;     // message is being finished
  logic       mark_q, mark_d;   // 0x80 marker already placed
  logic       lenh_q, lenh_d;   // length goes into the current block
  logic       lend_q, lend_d;   // length written, block is the last one
  logic [5:0] round_q, round_d;
  logic [2:0] widx_q, widx_d;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    mark_d  = mark_q;
    lenh_d  = lenh_q;
    lend_d  = lend_q;
    round_d = round_q;
    widx_d  = widx_q;
    cmd_o   = '0;
    cmd_o.byte_sel  = BYTE_ZERO;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = widx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.byte_sel  = BYTE_DATA;
            cmd_o.cnt_inc   = 1'b1;
          end
          if (byte_valid_i && status_i.pos_last) begin
            fin_d   = end_of_message_i;
            state_d = S_INIT;
          end else if (end_of_message_i) begin
            fin_d   = 1'b1;
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.load_byte = 1'b1;
        if (!mark_q) begin
          cmd_o.byte_sel = BYTE_MARK;
          mark_d = 1'b1;
          lenh_d = !status_i.pos_ge56;
        end else if (lenh_q && status_i.pos_ge56) begin
          cmd_o.byte_sel = BYTE_LEN;
        end
        if (status_i.pos_last) begin
          lend_d  = mark_q && lenh_q;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_work = 1'b1;
        round_d = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'(NumRounds - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_hash = 1'b1;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (lend_q) begin
          widx_d  = '0;
          state_d = S_OUT;
        end else begin
          lenh_d  = 1'b1;
          state_d = S_PAD;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            cmd_o.new_msg = 1'b1;
            fin_d   = 1'b0;
            mark_d  = 1'b0;
            lenh_d  = 1'b0;
            lend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenh_q  <= 1'b0;
      lend_q  <= 1'b0;
      round_q <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      lenh_q  <= lenh_d;
      lend_q  <= lend_d;
      round_q <= round_d;
      widx_q  <= widx_d;
    end
  end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher: byte-stream sha-256 hasher
// gathers message bytes into 64-byte blocks, compresses each block in 64
// rounds, pads on end of message and returns the digest as eight words
// ----------------------------------------------------------------------------
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   in      | sink      | data_byte_i, byte_valid_i, end_of_message_i
//   out     | source    | digest_word_o, word_index_o, last_word_o
//
// a byte beat is taken while the controller is idle; the beat that fills a block
// starts compression (load, 64 rounds on one shared round unit, chaining add)
// end of message pads one byte per cycle until the block is full, then
// compresses; a long tail costs a second padded block
// the digest words are held steady in the chaining registers until taken
// reset loads the initial hash values and clears the length count
//
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;

  // controller: intake, padding sequence, round count, output index
  sha_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // datapath: block shift line, counters, round unit, chaining words
  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .status_o      (status),
    .digest_word_o (digest_word_o)
  );

  // word index comes straight from the output counter
  assign word_index_o = cmd.out_idx;
  assign last_word_o  = (cmd.out_idx == 3'd7);

endmodule
